// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the band clipper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Full form: explicit clock and reset.
`define PBC_ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pbc assertion failed");

// Short form: the block's own clock and reset.
`define PBC_ASSERT(name, prop) \
   `PBC_ASSERT_CLK(name, clock, reset, prop)

`endif

// ===== sv/pbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbc_pkg
// Types and constants of the polygon band clipper.
// ----------------------------------------------------------------------------
package pbc_pkg;

   localparam int COORD_W   = 32;
   localparam int WIDE_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int CNT_W     = $clog2(PROD_W);
   localparam int CSR_IDX_W = 3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   typedef enum logic [1:0] {
      ZONE_IN = 2'd0,
      ZONE_LO = 2'd1,
      ZONE_HI = 2'd2
   } zone_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_AXIS = 3'd0,
      CSR_BAND_LOW  = 3'd1,
      CSR_BAND_HIGH = 3'd2,
      CSR_SHIFT_X   = 3'd3,
      CSR_SHIFT_Y   = 3'd4
   } csr_type;

   typedef enum logic [1:0] {
      PT_CROSS_LO = 2'd0,
      PT_CROSS_HI = 2'd1,
      PT_VERTEX   = 2'd2
   } point_type;

   // operands of a*b/c, each a difference of two coordinates
   typedef struct packed {
      wide_type a;
      wide_type b;
      wide_type c;
   } md_op_type;

   typedef struct packed {
      logic      done;
      coord_type q;
   } md_res_type;

endpackage

// ===== sv/pbc_muldiv.sv =====
// ----------------------------------------------------------------------------
// pbc_muldiv
// Shared a*b/c unit: one 32x32 product, then a 64-step restoring divide.
// Quotient truncated toward zero, low 32 bits; zero divisor gives 0.
// ----------------------------------------------------------------------------
module pbc_muldiv import pbc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  md_op_type  op,
   output md_res_type res
);

   typedef enum logic [2:0] {
      M_IDLE = 3'b001,
      M_MUL  = 3'b010,
      M_DIV  = 3'b100
   } mstate_type;

   mstate_type          state_ff, state_in;
   logic [COORD_W-1:0]  am_ff, am_in, bm_ff, bm_in, cm_ff, cm_in;
   logic                neg_ff, neg_in, cz_ff, cz_in;
   logic [PROD_W-1:0]   dvd_ff, dvd_in;
   logic [COORD_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   coord_type           q_ff, q_in;
   logic                done_ff, done_in;

   logic [PROD_W-1:0]   prod;
   logic [COORD_W:0]    rem_sh, diff;
   logic                ge;

   function automatic logic [COORD_W-1:0] mag(input wide_type v);
      logic [WIDE_W-1:0] n;
      n = v[WIDE_W-1] ? -v : v;
      return n[COORD_W-1:0];
   endfunction

   assign prod   = am_ff * bm_ff;
   assign rem_sh = {rem_ff, dvd_ff[PROD_W-1]};
   assign diff   = rem_sh - {1'b0, cm_ff};
   assign ge     = (rem_sh >= {1'b0, cm_ff});

   always_comb begin
      state_in = state_ff;
      am_in    = am_ff;
      bm_in    = bm_ff;
      cm_in    = cm_ff;
      neg_in   = neg_ff;
      cz_in    = cz_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               am_in    = mag(op.a);
               bm_in    = mag(op.b);
               cm_in    = mag(op.c);
               neg_in   = op.a[WIDE_W-1] ^ op.b[WIDE_W-1] ^ op.c[WIDE_W-1];
               cz_in    = (op.c == '0);
               state_in = M_MUL;
            end
         end
         M_MUL: begin
            dvd_in   = prod;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = M_DIV;
         end
         M_DIV: begin
            rem_in = ge ? diff[COORD_W-1:0] : rem_sh[COORD_W-1:0];
            dvd_in = {dvd_ff[PROD_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               // quotient bits have now filled the dividend register
               if (cz_ff)
                  q_in = '0;
               else if (neg_ff)
                  q_in = -coord_type'(dvd_in[COORD_W-1:0]);
               else
                  q_in = coord_type'(dvd_in[COORD_W-1:0]);
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      am_ff  <= am_in;
      bm_ff  <= bm_in;
      cm_ff  <= cm_in;
      neg_ff <= neg_in;
      cz_ff  <= cz_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
   end

   assign res.done = done_ff;
   assign res.q    = q_ff;

endmodule

// ===== sv/polygon_band_clip.sv =====
// ----------------------------------------------------------------------------
// polygon_band_clip
// Single-axis Sutherland-Hodgman pass: clips a closed integer polygon to a
// band on x or y, emitting crossings and kept vertices with an offset added.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | kind, vx, vy
//   rsp     | out       | rsp_valid/stall    | px, py, run_end
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// A prime beat or a vertex that emits nothing only updates the previous vertex.
// A crossing goes through issue, the product, 64 divide steps and the result;
// a kept vertex is formed directly, and each rsp beat waits out rsp_stall.
// A vertex emits at most two points. req_stall is high after an emitting vertex
// is accepted until its last rsp beat is taken.
// Reset is synchronous and clears the configuration registers, the previous vertex and state.
// ----------------------------------------------------------------------------
module polygon_band_clip import pbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic signed [COORD_W-1:0] req_vx,
   input  logic signed [COORD_W-1:0] req_vy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [COORD_W-1:0] rsp_px,
   output logic signed [COORD_W-1:0] rsp_py,
   output logic                  rsp_run_end
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PREP = 4'b0010,
      S_WAIT = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type  state_ff, state_in;

   logic       axis_ff;
   coord_type  band_low_ff, band_high_ff, shift_x_ff, shift_y_ff;

   coord_type  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   zone_type   prev_zone_ff, prev_zone_in;
   coord_type  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   zone_type   cur_zone_ff, cur_zone_in;
   point_type  op0_ff, op0_in, op1_ff, op1_in;
   logic       two_ff, two_in;
   logic       idx_ff, idx_in;
   coord_type  px_ff, px_in, py_ff, py_in;
   logic       run_end_ff, run_end_in;

   zone_type   zone_new;
   point_type  plan0, plan1, cur_op;
   logic [1:0] plan_n;
   logic       is_last, req_fire;
   coord_type  bound, lm, lo, tm, to, other;
   logic       md_start;
   md_op_type  md_op;
   md_res_type md_res;

   function automatic zone_type classify(input coord_type m, input coord_type lo_b,
                                         input coord_type hi_b);
      zone_type z;
      priority if (m <= lo_b) z = ZONE_LO;
      else if (m >= hi_b)     z = ZONE_HI;
      else                    z = ZONE_IN;
      return z;
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= 1'b0;
         band_low_ff  <= '0;
         band_high_ff <= '0;
         shift_x_ff   <= '0;
         shift_y_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_CLIP_AXIS: axis_ff      <= csr_wdata[0];
            CSR_BAND_LOW:  band_low_ff  <= csr_wdata;
            CSR_BAND_HIGH: band_high_ff <= csr_wdata;
            CSR_SHIFT_X:   shift_x_ff   <= csr_wdata;
            CSR_SHIFT_Y:   shift_y_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_fire = req_valid && !req_stall;
   assign zone_new = classify(axis_ff ? req_vx : req_vy, band_low_ff, band_high_ff);

   // points this vertex emits, in order
   always_comb begin
      plan0  = PT_VERTEX;
      plan1  = PT_VERTEX;
      plan_n = 2'd0;
      unique case (zone_new)
         ZONE_LO: begin
            if (prev_zone_ff == ZONE_IN) begin
               plan0 = PT_CROSS_LO; plan_n = 2'd1;
            end else if (prev_zone_ff == ZONE_HI) begin
               plan0 = PT_CROSS_HI; plan1 = PT_CROSS_LO; plan_n = 2'd2;
            end
         end
         ZONE_HI: begin
            if (prev_zone_ff == ZONE_IN) begin
               plan0 = PT_CROSS_HI; plan_n = 2'd1;
            end else if (prev_zone_ff == ZONE_LO) begin
               plan0 = PT_CROSS_LO; plan1 = PT_CROSS_HI; plan_n = 2'd2;
            end
         end
         default: begin
            if (prev_zone_ff == ZONE_IN) begin
               // an inside vertex repeating the previous one is dropped
               if (req_vx != prev_x_ff || req_vy != prev_y_ff)
                  plan_n = 2'd1;
            end else begin
               plan0  = (prev_zone_ff == ZONE_LO) ? PT_CROSS_LO : PT_CROSS_HI;
               plan_n = 2'd2;
            end
         end
      endcase
   end

   assign cur_op  = idx_ff ? op1_ff : op0_ff;
   assign is_last = idx_ff || !two_ff;

   // crossing operands on the chosen axis
   assign bound = (cur_op == PT_CROSS_LO) ? band_low_ff : band_high_ff;
   assign lm    = axis_ff ? prev_x_ff : prev_y_ff;
   assign lo    = axis_ff ? prev_y_ff : prev_x_ff;
   assign tm    = axis_ff ? cur_x_ff  : cur_y_ff;
   assign to    = axis_ff ? cur_y_ff  : cur_x_ff;

   assign md_op.a = {to[COORD_W-1], to} - {lo[COORD_W-1], lo};
   assign md_op.b = {bound[COORD_W-1], bound} - {lm[COORD_W-1], lm};
   assign md_op.c = {tm[COORD_W-1], tm} - {lm[COORD_W-1], lm};
   assign other   = lo + md_res.q;

   pbc_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .op    (md_op),
      .res   (md_res)
   );

   always_comb begin
      state_in     = state_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_zone_in = prev_zone_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_zone_in  = cur_zone_ff;
      op0_in       = op0_ff;
      op1_in       = op1_ff;
      two_in       = two_ff;
      idx_in       = idx_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      run_end_in   = run_end_ff;
      md_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_kind || plan_n == 2'd0) begin
                  prev_x_in    = req_vx;
                  prev_y_in    = req_vy;
                  prev_zone_in = zone_new;
               end else begin
                  cur_x_in    = req_vx;
                  cur_y_in    = req_vy;
                  cur_zone_in = zone_new;
                  op0_in      = plan0;
                  op1_in      = plan1;
                  two_in      = (plan_n == 2'd2);
                  idx_in      = 1'b0;
                  state_in    = S_PREP;
               end
            end
         end
         S_PREP: begin
            if (cur_op == PT_VERTEX) begin
               px_in      = cur_x_ff + shift_x_ff;
               py_in      = cur_y_ff + shift_y_ff;
               run_end_in = is_last;
               state_in   = S_OUT;
            end else begin
               md_start = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (md_res.done) begin
               px_in      = (axis_ff ? bound : other) + shift_x_ff;
               py_in      = (axis_ff ? other : bound) + shift_y_ff;
               run_end_in = is_last;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (is_last) begin
                  prev_x_in    = cur_x_ff;
                  prev_y_in    = cur_y_ff;
                  prev_zone_in = cur_zone_ff;
                  state_in     = S_IDLE;
               end else begin
                  idx_in   = 1'b1;
                  state_in = S_PREP;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_zone_ff <= ZONE_IN;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_zone_ff <= prev_zone_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_zone_ff <= cur_zone_in;
      op0_ff      <= op0_in;
      op1_ff      <= op1_in;
      two_ff      <= two_in;
      idx_ff      <= idx_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      run_end_ff  <= run_end_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_OUT);
   assign rsp_px      = px_ff;
   assign rsp_py      = py_ff;
   assign rsp_run_end = run_end_ff;

endmodule

// ===== sv/pbc_checker.sv =====
// ----------------------------------------------------------------------------
// pbc_checker
// Port-level checks of the band clipper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_we,
   input logic [2:0]  csr_index,
   input logic [31:0] csr_wdata,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_kind,
   input logic [31:0] req_vx,
   input logic [31:0] req_vy,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_px,
   input logic [31:0] rsp_py,
   input logic        rsp_run_end
);

   // a held beat keeps its point
   `PBC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_px) && $stable(rsp_py))

   // no new vertex is taken while a point is pending
   `PBC_ASSERT(a_busy_out, rsp_valid |-> req_stall)

   // a prime beat never yields a point
   `PBC_ASSERT(a_prime_silent, req_valid && !req_stall && !req_kind |=> !rsp_valid)

   // the beat closing a vertex's run returns the block to idle
   `PBC_ASSERT(a_run_close, rsp_valid && !rsp_stall && rsp_run_end |=> !rsp_valid && !req_stall)

endmodule

bind polygon_band_clip pbc_checker u_pbc_checker (.*);
